// ===== rtl/pvk_pkg.sv =====
// shared types, constants and lookup functions for the primitive vertex kick assembler
package pvk_pkg;

  localparam int VERTEX_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH      = 2;

  localparam int WORD_W     = 64;
  localparam int INDEX_W    = 8;
  localparam int PRIM_W     = 3;
  localparam int VCAP_W     = 9;
  localparam int ICAP_W     = 16;
  localparam int ICOUNT_W   = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_VERTS  = 3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PRIM_TYPE       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_CAPACITY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_CAPACITY  = 2'd2;

  localparam logic [PRIM_W-1:0] PRIM_TYPE_RST       = 3'd0;
  localparam logic [VCAP_W-1:0] VERTEX_CAPACITY_RST = 9'd256;
  localparam logic [ICAP_W-1:0] INDEX_CAPACITY_RST  = 16'd65535;

  // input actions
  localparam logic ACTION_KICK  = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef enum logic [PRIM_W-1:0] {
    PRIM_POINT     = 3'd0,
    PRIM_LINE      = 3'd1,
    PRIM_LINESTRIP = 3'd2,
    PRIM_TRI       = 3'd3,
    PRIM_TRISTRIP  = 3'd4,
    PRIM_FAN       = 3'd5,
    PRIM_SPRITE    = 3'd6,
    PRIM_INVALID   = 3'd7
  } prim_t;

  // command from the front end to the back end
  typedef struct packed {
    logic                 overflow;
    logic [1:0]           cnt;
    logic                 copy;
    logic                 wr_en;
    logic [MAX_VERTS-1:0] use_word;
  } cmd_ctrl_t;

  // vertices pending before a primitive can be drawn
  function automatic logic [1:0] need_of(prim_t p);
    logic [1:0] n;
    case (p) inside
      PRIM_POINT, PRIM_INVALID:            n = 2'd1;
      PRIM_LINE, PRIM_LINESTRIP, PRIM_SPRITE: n = 2'd2;
      default:                             n = 2'd3;
    endcase
    return n;
  endfunction

  // indices emitted per drawn primitive
  function automatic logic [1:0] emit_of(prim_t p);
    logic [1:0] n;
    case (p) inside
      PRIM_POINT:                          n = 2'd1;
      PRIM_INVALID:                        n = 2'd0;
      PRIM_LINE, PRIM_LINESTRIP, PRIM_SPRITE: n = 2'd2;
      default:                             n = 2'd3;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/pvk_ram.sv =====
// generic single-write single-read ram with registered read data
module pvk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pvk_queue.sv =====
// short command fifo between the front end and the back end
module pvk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pvk_pkg::QUEUE_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pvk_front.sv =====
// front end: accepts words, tracks head, tail, next and index budget, builds store commands
module pvk_front #(
  parameter int VERTEX_DEPTH = pvk_pkg::VERTEX_DEPTH_DEF,
  localparam int AW = $clog2(VERTEX_DEPTH),
  localparam int SW = $clog2(VERTEX_DEPTH + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [pvk_pkg::PRIM_W-1:0]                 prim_type,
  input  logic [pvk_pkg::VCAP_W-1:0]                 vertex_capacity,
  input  logic [pvk_pkg::ICAP_W-1:0]                 index_capacity,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       in_action,
  input  logic [pvk_pkg::WORD_W-1:0]                 in_vertex_word,
  input  logic                                       in_skip,
  input  logic                                       q_full,
  output logic                                       cmd_push,
  output pvk_pkg::cmd_ctrl_t                         cmd_ctrl,
  output logic [pvk_pkg::WORD_W-1:0]                 cmd_word,
  output logic [AW-1:0]                              cmd_wr_slot,
  output logic [pvk_pkg::MAX_VERTS-1:0][AW-1:0]      cmd_src,
  output logic [pvk_pkg::MAX_VERTS-1:0][AW-1:0]      cmd_dst
);

  localparam int CW = (SW > pvk_pkg::VCAP_W) ? SW : pvk_pkg::VCAP_W;
  localparam int IW = pvk_pkg::ICOUNT_W;
  localparam int BW = pvk_pkg::ICOUNT_W + 1;
  localparam int NV = pvk_pkg::MAX_VERTS;

  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] next_r, next_nxt;
  logic [IW-1:0] index_count_r, index_count_nxt;

  pvk_pkg::prim_t prim;
  logic [1:0]     need, emit, k;
  logic [SW-1:0]  t, pending, base;
  logic [CW-1:0]  cap_cfg, cap;
  logic           accept, enough, draws, strip, compact, over;
  logic [SW-1:0]  src_s [NV];
  logic [SW-1:0]  dst_s [NV];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign prim     = pvk_pkg::prim_t'(prim_type);

  // classification of the incoming word
  always_comb begin
    need    = pvk_pkg::need_of(prim);
    emit    = pvk_pkg::emit_of(prim);
    t       = tail_r + SW'(1);
    pending = t - head_r;
    enough  = (pending >= SW'(need));
    draws   = enough && !in_skip;
    k       = draws ? emit : 2'd0;
    cap_cfg = CW'(vertex_capacity);
    cap     = (cap_cfg > CW'(VERTEX_DEPTH)) ? CW'(VERTEX_DEPTH) : cap_cfg;
    over    = (CW'(tail_r) >= cap) ||
              (({1'b0, index_count_r} + BW'(k)) > BW'(index_capacity));
    strip   = (prim == pvk_pkg::PRIM_LINESTRIP) || (prim == pvk_pkg::PRIM_TRISTRIP);
    compact = strip && draws && (next_r < head_r);
    base    = compact ? next_r : head_r;
    for (int i = 0; i < NV; i++) begin
      src_s[i] = head_r + SW'(i);
      dst_s[i] = base + SW'(i);
    end
    // fan: hub vertex plus the two newest
    if (prim == pvk_pkg::PRIM_FAN) begin
      src_s[1] = t - SW'(2);
      src_s[2] = t - SW'(1);
      dst_s[1] = src_s[1];
      dst_s[2] = src_s[2];
    end
  end

  // state update
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    next_nxt        = next_r;
    index_count_nxt = index_count_r;
    if (accept) begin
      if (in_action == pvk_pkg::ACTION_FLUSH) begin
        head_nxt        = '0;
        tail_nxt        = '0;
        next_nxt        = '0;
        index_count_nxt = '0;
      end else if (!over) begin
        tail_nxt = t;
        if (enough && in_skip) begin
          unique case (prim) inside
            pvk_pkg::PRIM_LINESTRIP, pvk_pkg::PRIM_TRISTRIP: head_nxt = head_r + SW'(1);
            pvk_pkg::PRIM_FAN:                               head_nxt = head_r;
            default:                                         tail_nxt = head_r;
          endcase
        end else if (enough) begin
          unique case (prim) inside
            pvk_pkg::PRIM_LINESTRIP, pvk_pkg::PRIM_TRISTRIP: begin
              head_nxt = base + SW'(1);
              next_nxt = base + SW'(emit);
              if (compact) begin
                tail_nxt = base + SW'(emit);
              end
            end
            pvk_pkg::PRIM_FAN: begin
              next_nxt = t;
            end
            pvk_pkg::PRIM_INVALID: begin
              tail_nxt = head_r;
            end
            default: begin
              head_nxt = head_r + SW'(emit);
              next_nxt = head_r + SW'(emit);
            end
          endcase
          index_count_nxt = index_count_r + IW'(k);
        end
      end
    end
  end

  // command to the back end
  always_comb begin
    cmd_push          = accept && (in_action == pvk_pkg::ACTION_KICK);
    cmd_ctrl.overflow = over;
    cmd_ctrl.cnt      = over ? 2'd0 : k;
    cmd_ctrl.copy     = compact && !over;
    // after compaction the old tail slot is dead, so the word is not stored there
    cmd_ctrl.wr_en    = !over && !compact;
    cmd_word          = in_vertex_word;
    cmd_wr_slot       = tail_r[AW-1:0];
    for (int i = 0; i < NV; i++) begin
      cmd_ctrl.use_word[i] = (src_s[i] == tail_r);
      cmd_src[i]           = src_s[i][AW-1:0];
      cmd_dst[i]           = dst_s[i][AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      next_r        <= '0;
      index_count_r <= '0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      next_r        <= next_nxt;
      index_count_r <= index_count_nxt;
    end
  end

  a_head_not_past_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("head slot beyond tail slot");

  a_index_budget_bound: assert property (@(posedge clk) disable iff (!rst_n)
    index_count_r[IW-1] == 1'b0)
    else $error("index count beyond largest budget");

endmodule

// ===== rtl/pvk_back.sv =====
// back end: executes store commands, one store read per emitted index, drives results
module pvk_back #(
  parameter int VERTEX_DEPTH = pvk_pkg::VERTEX_DEPTH_DEF,
  localparam int AW = $clog2(VERTEX_DEPTH)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  pvk_pkg::cmd_ctrl_t                    q_ctrl,
  input  logic [pvk_pkg::WORD_W-1:0]            q_word,
  input  logic [AW-1:0]                         q_wr_slot,
  input  logic [pvk_pkg::MAX_VERTS-1:0][AW-1:0] q_src,
  input  logic [pvk_pkg::MAX_VERTS-1:0][AW-1:0] q_dst,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pvk_pkg::INDEX_W-1:0]           out_vertex_index,
  output logic [pvk_pkg::WORD_W-1:0]            out_vertex_data,
  output logic                                  out_overflow,
  output logic                                  out_last
);

  localparam int IW = pvk_pkg::INDEX_W;
  localparam int WW = pvk_pkg::WORD_W;

  typedef struct packed {
    logic          out_load;
    logic [IW-1:0] index;
    logic          last;
    logic          overflow;
    logic          use_word;
    logic          wr_en;
    logic          wr_copy;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] word;
    logic          fwd;
    logic [WW-1:0] fwd_data;
  } beat_t;

  logic [1:0]    beat_r, beat_nxt;
  logic          w_valid_r, w_valid_nxt;
  beat_t         w_beat_r, beat_new;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_vertex_index_r;
  logic [WW-1:0] out_vertex_data_r;
  logic          out_overflow_r, out_last_r;

  logic          last_beat, r_adv, rd_en, w_fire, w_we;
  logic [AW-1:0] rd_addr;
  logic [WW-1:0] ram_rdata, beat_data, w_wr_data;

  // issue stage: one beat per emitted index, one beat for a command without indices
  assign last_beat = (q_ctrl.cnt == 2'd0) || (beat_r == q_ctrl.cnt - 2'd1);
  assign w_fire    = w_valid_r && (!w_beat_r.out_load || !out_valid_r || out_ready);
  assign r_adv     = q_valid && (!w_valid_r || w_fire);
  assign rd_en     = r_adv && (q_ctrl.cnt != 2'd0);
  assign rd_addr   = q_src[beat_r];
  assign q_pop     = r_adv && last_beat;

  always_comb begin
    beat_nxt = beat_r;
    if (r_adv) begin
      beat_nxt = last_beat ? 2'd0 : beat_r + 2'd1;
    end
  end

  always_comb begin
    beat_new.out_load = (q_ctrl.cnt != 2'd0) || q_ctrl.overflow;
    beat_new.index    = (q_ctrl.cnt != 2'd0) ? IW'(q_dst[beat_r]) : '0;
    beat_new.last     = last_beat;
    beat_new.overflow = q_ctrl.overflow;
    beat_new.use_word = (q_ctrl.cnt != 2'd0) && q_ctrl.use_word[beat_r];
    beat_new.wr_copy  = (q_ctrl.cnt != 2'd0) && q_ctrl.copy;
    beat_new.wr_en    = beat_new.wr_copy || (last_beat && q_ctrl.wr_en);
    beat_new.wr_addr  = beat_new.wr_copy ? q_dst[beat_r] : q_wr_slot;
    beat_new.word     = q_word;
    // a write leaving the second stage in the same cycle is not yet in the ram
    beat_new.fwd      = w_we && (w_beat_r.wr_addr == rd_addr);
    beat_new.fwd_data = w_wr_data;
  end

  // second stage: read data arrives, result is loaded, store is written
  always_comb begin
    if (w_beat_r.use_word) begin
      beat_data = w_beat_r.word;
    end else if (w_beat_r.fwd) begin
      beat_data = w_beat_r.fwd_data;
    end else begin
      beat_data = ram_rdata;
    end
    w_wr_data = w_beat_r.wr_copy ? beat_data : w_beat_r.word;
    w_we      = w_fire && w_beat_r.wr_en;
  end

  always_comb begin
    w_valid_nxt = w_valid_r;
    if (r_adv) begin
      w_valid_nxt = 1'b1;
    end else if (w_fire) begin
      w_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (w_fire && w_beat_r.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  pvk_ram #(
    .WIDTH (WW),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_beat_r.wr_addr),
    .wdata (w_wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= 2'd0;
      w_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      w_valid_r   <= w_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      w_beat_r <= beat_new;
    end
    if (w_fire && w_beat_r.out_load) begin
      out_vertex_index_r <= w_beat_r.index;
      out_vertex_data_r  <= w_beat_r.overflow ? '0 : beat_data;
      out_overflow_r     <= w_beat_r.overflow;
      out_last_r         <= w_beat_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_vertex_index_r;
  assign out_vertex_data  = out_vertex_data_r;
  assign out_overflow     = out_overflow_r;
  assign out_last         = out_last_r;

  a_beat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && (q_ctrl.cnt != 2'd0) |-> beat_r < q_ctrl.cnt)
    else $error("beat counter beyond index count of command");

  a_overflow_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_overflow_r |-> out_last_r && (out_vertex_data_r == '0)
      && (out_vertex_index_r == '0))
    else $error("overflow word not alone or carries data");

endmodule

// ===== rtl/primitive_vertex_kick_assembler.sv =====
// top level of the primitive vertex kick assembler: config registers, front end, queue, back end
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in_     | input     | in_valid / in_ready  | in_action, in_vertex_word, in_skip
//  out_    | output    | out_valid/out_ready  | out_vertex_index, out_vertex_data,
//          |           |                      | out_overflow, out_last
//  cfg_    | input     | cfg_we (no wait)     | cfg_addr, cfg_data
//
//  indices: a kick emits k indices (0 to 3): drawing triangle, triangle strip and fan words 3,
//    drawing line, line strip and sprite words 2, drawing point words 1, everything else 0;
//    the one store read port serves one emitted index per cycle unless out_ready holds the back end
//  path: a drawing word passes the command queue, the second-stage register and the output register
//  reset: synchronous; the vertex store is not cleared and needs no sweep
//  stalls: a 2-entry command queue lets the front accept while the back waits on out_ready;
//    a flush word causes no result
module primitive_vertex_kick_assembler #(
  parameter int VERTEX_DEPTH = pvk_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [pvk_pkg::WORD_W-1:0]         in_vertex_word,
  input  logic                               in_skip,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pvk_pkg::INDEX_W-1:0]        out_vertex_index,
  output logic [pvk_pkg::WORD_W-1:0]         out_vertex_data,
  output logic                               out_overflow,
  output logic                               out_last,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [pvk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pvk_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(VERTEX_DEPTH);
  localparam int NV    = pvk_pkg::MAX_VERTS;
  localparam int CMD_W = $bits(pvk_pkg::cmd_ctrl_t) + pvk_pkg::WORD_W + (2 * NV + 1) * AW;

  // configuration registers
  logic [pvk_pkg::PRIM_W-1:0] prim_type_r;
  logic [pvk_pkg::VCAP_W-1:0] vertex_capacity_r;
  logic [pvk_pkg::ICAP_W-1:0] index_capacity_r;

  // front to queue
  logic                         cmd_push;
  pvk_pkg::cmd_ctrl_t           cmd_ctrl;
  logic [pvk_pkg::WORD_W-1:0]   cmd_word;
  logic [AW-1:0]                cmd_wr_slot;
  logic [NV-1:0][AW-1:0]        cmd_src;
  logic [NV-1:0][AW-1:0]        cmd_dst;
  logic [CMD_W-1:0]             q_wdata;
  logic                         q_full;

  // queue to back
  logic                         q_valid;
  logic                         q_pop;
  logic [CMD_W-1:0]             q_rdata;
  pvk_pkg::cmd_ctrl_t           q_ctrl;
  logic [pvk_pkg::WORD_W-1:0]   q_word;
  logic [AW-1:0]                q_wr_slot;
  logic [NV-1:0][AW-1:0]        q_src;
  logic [NV-1:0][AW-1:0]        q_dst;

  // register writes take effect at once; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_type_r       <= pvk_pkg::PRIM_TYPE_RST;
      vertex_capacity_r <= pvk_pkg::VERTEX_CAPACITY_RST;
      index_capacity_r  <= pvk_pkg::INDEX_CAPACITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pvk_pkg::CFG_PRIM_TYPE:       prim_type_r       <= cfg_data[pvk_pkg::PRIM_W-1:0];
        pvk_pkg::CFG_VERTEX_CAPACITY: vertex_capacity_r <= cfg_data[pvk_pkg::VCAP_W-1:0];
        pvk_pkg::CFG_INDEX_CAPACITY:  index_capacity_r  <= cfg_data;
        default:                      prim_type_r       <= prim_type_r;
      endcase
    end
  end

  // front end: slot bookkeeping and classification, one word per cycle while the queue is not full
  pvk_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .prim_type       (prim_type_r),
    .vertex_capacity (vertex_capacity_r),
    .index_capacity  (index_capacity_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_vertex_word  (in_vertex_word),
    .in_skip         (in_skip),
    .q_full          (q_full),
    .cmd_push        (cmd_push),
    .cmd_ctrl        (cmd_ctrl),
    .cmd_word        (cmd_word),
    .cmd_wr_slot     (cmd_wr_slot),
    .cmd_src         (cmd_src),
    .cmd_dst         (cmd_dst)
  );

  // commands travel packed through the queue
  assign q_wdata = {cmd_ctrl, cmd_word, cmd_wr_slot, cmd_src, cmd_dst};
  assign {q_ctrl, q_word, q_wr_slot, q_src, q_dst} = q_rdata;

  pvk_queue #(
    .WIDTH (CMD_W),
    .DEPTH (pvk_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back end: vertex store, compaction copies and result words
  pvk_back #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_ctrl           (q_ctrl),
    .q_word           (q_word),
    .q_wr_slot        (q_wr_slot),
    .q_src            (q_src),
    .q_dst            (q_dst),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_vertex_data  (out_vertex_data),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

endmodule

// ===== tb/sv/primitive_vertex_kick_assembler_tb.sv =====
// testbench for the primitive vertex kick assembler: queued kick driver, stalling receiver, index checker
module primitive_vertex_kick_assembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W           = pvk_pkg::WORD_W;
  localparam int INDEX_W          = pvk_pkg::INDEX_W;
  localparam int PRIM_W           = pvk_pkg::PRIM_W;
  localparam int VCAP_W           = pvk_pkg::VCAP_W;
  localparam int ICAP_W           = pvk_pkg::ICAP_W;
  localparam int ICOUNT_W         = pvk_pkg::ICOUNT_W;
  localparam int CFG_ADDR_W       = pvk_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W       = pvk_pkg::CFG_DATA_W;
  localparam int MAX_VERTS        = pvk_pkg::MAX_VERTS;
  localparam int VERTEX_DEPTH_DEF = pvk_pkg::VERTEX_DEPTH_DEF;

  // one kick word as offered on the input channel
  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] vertex;
    logic              skip;
  } kick_t;

  // one index word as it should leave the result channel
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  data;
    logic               ovf;
    logic               last;
  } index_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic                  in_action      = pvk_pkg::ACTION_KICK;
  logic [WORD_W-1:0]     in_vertex_word = '0;
  logic                  in_skip        = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [INDEX_W-1:0]    out_vertex_index;
  logic [WORD_W-1:0]     out_vertex_data;
  logic                  out_overflow;
  logic                  out_last;
  logic                  cfg_we         = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr       = pvk_pkg::CFG_PRIM_TYPE;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  // kick words waiting for the driver, index words waiting for the block
  kick_t       kick_q[$];
  index_word_t emitted_q[$];

  // shadow of the block: vertex store, slot pointers, index budget, registers
  logic [WORD_W-1:0]   vstore [VERTEX_DEPTH_DEF];
  logic [VCAP_W-1:0]   head     = '0;
  logic [VCAP_W-1:0]   tail     = '0;
  logic [VCAP_W-1:0]   nxt_slot = '0;
  logic [ICOUNT_W-1:0] icount   = '0;
  pvk_pkg::prim_t      cur_prim = pvk_pkg::PRIM_POINT;
  logic [VCAP_W-1:0]   cur_vcap = pvk_pkg::VERTEX_CAPACITY_RST;
  logic [ICAP_W-1:0]   cur_icap = pvk_pkg::INDEX_CAPACITY_RST;

  int   n_errors   = 0;
  int   n_accepted = 0;
  int   in_gap     = 0;
  int   out_gap    = 0;
  logic no_idle    = 1'b0;
  logic hold_out   = 1'b0;

  primitive_vertex_kick_assembler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_vertex_word   (in_vertex_word),
    .in_skip          (in_skip),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_vertex_index (out_vertex_index),
    .out_vertex_data  (out_vertex_data),
    .out_overflow     (out_overflow),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // vertices that must be pending before a primitive closes
  function automatic int verts_needed(pvk_pkg::prim_t p);
    case (p)
      pvk_pkg::PRIM_POINT, pvk_pkg::PRIM_INVALID:                    return 1;
      pvk_pkg::PRIM_LINE, pvk_pkg::PRIM_LINESTRIP, pvk_pkg::PRIM_SPRITE: return 2;
      default:                                                         return 3;
    endcase
  endfunction

  // indices one closed primitive puts out
  function automatic int indices_drawn(pvk_pkg::prim_t p);
    case (p)
      pvk_pkg::PRIM_POINT:                                             return 1;
      pvk_pkg::PRIM_INVALID:                                           return 0;
      pvk_pkg::PRIM_LINE, pvk_pkg::PRIM_LINESTRIP, pvk_pkg::PRIM_SPRITE: return 2;
      default:                                                         return 3;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    n_errors++;
    $display("mismatch %0t ns: %s got %h want %h", $time, what, got, want);
  endtask

  // advance the shadow by one accepted kick word and queue the index words it draws
  task automatic kick_vertex(input logic action, input logic [WORD_W-1:0] vertex,
                             input logic skip);
    logic [VCAP_W-1:0] t;
    logic [VCAP_W-1:0] h;
    logic [VCAP_W-1:0] cap;
    logic [VCAP_W-1:0] slots [MAX_VERTS];
    int                need;
    int                k;
    int                n;
    index_word_t       w;
    if (action == pvk_pkg::ACTION_FLUSH) begin
      // flush clears pointers and budget, store contents stay
      head     = '0;
      tail     = '0;
      nxt_slot = '0;
      icount   = '0;
      return;
    end
    cap  = (cur_vcap > 9'd256) ? 9'd256 : cur_vcap;
    t    = tail + 9'd1;
    h    = head;
    need = verts_needed(cur_prim);
    k    = ((t - h) >= need && !skip) ? indices_drawn(cur_prim) : 0;
    // store full or index budget spent: vertex dropped, one overflow word, no state change
    if (tail >= cap || icount + k > cur_icap) begin
      w.idx  = '0;
      w.data = '0;
      w.ovf  = 1'b1;
      w.last = 1'b1;
      emitted_q.push_back(w);
      return;
    end
    vstore[tail] = vertex;
    tail = t;
    if ((t - h) < need)
      return;
    if (skip) begin
      // strips slide the head, fans keep everything, list types drop the pending set
      if (cur_prim == pvk_pkg::PRIM_LINESTRIP || cur_prim == pvk_pkg::PRIM_TRISTRIP)
        head = h + 9'd1;
      else if (cur_prim != pvk_pkg::PRIM_FAN)
        tail = h;
      return;
    end
    case (cur_prim)
      pvk_pkg::PRIM_LINESTRIP, pvk_pkg::PRIM_TRISTRIP: begin
        n = (cur_prim == pvk_pkg::PRIM_LINESTRIP) ? 2 : 3;
        // a gap below the head: live vertices move down to the next slot first
        if (nxt_slot < h) begin
          for (int i = 0; i < n; i++)
            vstore[nxt_slot + i] = vstore[h + i];
          h    = nxt_slot;
          tail = VCAP_W'(h + n);
        end
        for (int i = 0; i < n; i++)
          slots[i] = VCAP_W'(h + i);
        head     = h + 9'd1;
        nxt_slot = VCAP_W'(h + n);
      end
      pvk_pkg::PRIM_FAN: begin
        // fan pivots on the head, which never moves
        slots[0] = h;
        slots[1] = t - 9'd2;
        slots[2] = t - 9'd1;
        nxt_slot = t;
      end
      pvk_pkg::PRIM_INVALID: begin
        tail = h;
        return;
      end
      default: begin
        for (int i = 0; i < k; i++)
          slots[i] = VCAP_W'(h + i);
        head     = VCAP_W'(h + k);
        nxt_slot = VCAP_W'(h + k);
      end
    endcase
    icount = ICOUNT_W'(icount + k);
    for (int i = 0; i < k; i++) begin
      w.idx  = slots[i][INDEX_W-1:0];
      w.data = vstore[slots[i]];
      w.ovf  = 1'b0;
      w.last = (i == k - 1);
      emitted_q.push_back(w);
    end
  endtask

  // input side: predict on acceptance, then offer the next kick word or idle a burst
  always @(posedge clk) begin : drive_kicks
    kick_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        kick_vertex(in_action, in_vertex_word, in_skip);
        n_accepted++;
      end
      // payload may only change once the current word is gone
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!no_idle && kick_q.size() != 0 && $urandom_range(99) < 10) begin
          in_gap   = $urandom_range(7, 0);
          in_valid <= 1'b0;
        end else if (kick_q.size() != 0) begin
          item = kick_q.pop_front();
          in_valid       <= 1'b1;
          in_action      <= item.action;
          in_vertex_word <= item.vertex;
          in_skip        <= item.skip;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: random stall bursts, plus the long hold-off
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 10) begin
      out_gap   = $urandom_range(7, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_out;
    end
  end

  // every accepted result word against the oldest prediction
  always @(posedge clk) begin : check_results
    index_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (emitted_q.size() == 0) begin
        report_mismatch("result word with nothing due", WORD_W'(out_vertex_index), '0);
      end else begin
        want = emitted_q.pop_front();
        if (out_vertex_index !== want.idx)
          report_mismatch("vertex_index", WORD_W'(out_vertex_index), WORD_W'(want.idx));
        if (out_vertex_data !== want.data)
          report_mismatch("vertex_data", out_vertex_data, want.data);
        if (out_overflow !== want.ovf)
          report_mismatch("overflow", WORD_W'(out_overflow), WORD_W'(want.ovf));
        if (out_last !== want.last)
          report_mismatch("last", WORD_W'(out_last), WORD_W'(want.last));
      end
    end
  end

  // receiver goes dark for a long stretch mid run so the block backs up into in_ready
  initial begin : long_hold
    wait (n_accepted >= 300);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (80) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    case (addr)
      pvk_pkg::CFG_PRIM_TYPE:       cur_prim = pvk_pkg::prim_t'(data[PRIM_W-1:0]);
      pvk_pkg::CFG_VERTEX_CAPACITY: cur_vcap = data[VCAP_W-1:0];
      pvk_pkg::CFG_INDEX_CAPACITY:  cur_icap = data[ICAP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_config(input pvk_pkg::prim_t p, input int vcap, input int icap);
    write_reg(pvk_pkg::CFG_PRIM_TYPE, CFG_DATA_W'(p));
    write_reg(pvk_pkg::CFG_VERTEX_CAPACITY, CFG_DATA_W'(vcap));
    write_reg(pvk_pkg::CFG_INDEX_CAPACITY, CFG_DATA_W'(icap));
    // new words are queued away from the edge the driver pops on
    @(negedge clk);
  endtask

  // sender pauses until every due word is back, then lets the pipe run dry
  task automatic settle();
    do @(negedge clk);
    while (kick_q.size() != 0 || in_valid || emitted_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_kick(input logic action, input logic [WORD_W-1:0] vertex,
                          input logic skip);
    kick_t item;
    item.action = action;
    item.vertex = vertex;
    item.skip   = skip;
    kick_q.push_back(item);
  endtask

  function automatic logic [WORD_W-1:0] random_vertex();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_random(input pvk_pkg::prim_t p, input int vcap, input int icap,
                            input int flush_pct, input int skip_pct, input int count,
                            input logic lead_flush);
    logic action;
    settle();
    write_config(p, vcap, icap);
    if (lead_flush)
      add_kick(pvk_pkg::ACTION_FLUSH, random_vertex(), 1'($urandom_range(1)));
    for (int i = 0; i < count; i++) begin
      action = ($urandom_range(99) < flush_pct) ? pvk_pkg::ACTION_FLUSH : pvk_pkg::ACTION_KICK;
      add_kick(action, random_vertex(), $urandom_range(99) < skip_pct);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // points at reset settings: data extremes, list skip, flush
    settle();
    write_config(pvk_pkg::PRIM_POINT, 256, 65535);
    add_kick(pvk_pkg::ACTION_KICK, '0, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, '1, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h5555_5555_5555_5555, 1'b1);
    add_kick(pvk_pkg::ACTION_FLUSH, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);

    // line strip: two skips open a gap, the next draw compacts down to it
    settle();
    write_config(pvk_pkg::PRIM_LINESTRIP, 256, 65535);
    add_kick(pvk_pkg::ACTION_KICK, 64'h0123_4567_89ab_cdef, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'hfedc_ba98_7654_3210, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h1111_2222_3333_4444, 1'b1);
    add_kick(pvk_pkg::ACTION_KICK, 64'h5555_6666_7777_8888, 1'b1);
    add_kick(pvk_pkg::ACTION_KICK, 64'h9999_aaaa_bbbb_cccc, 1'b0);

    // fan at the smallest store: one triangle, then the store is full
    settle();
    write_config(pvk_pkg::PRIM_FAN, 3, 65535);
    add_kick(pvk_pkg::ACTION_FLUSH, '0, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h0000_0000_0000_0001, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h8000_0000_0000_0000, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'hdead_beef_cafe_f00d, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h0bad_0bad_0bad_0bad, 1'b0);

    // invalid type drops the vertex without a word
    settle();
    write_config(pvk_pkg::PRIM_INVALID, 3, 65535);
    add_kick(pvk_pkg::ACTION_FLUSH, '1, 1'b1);
    add_kick(pvk_pkg::ACTION_KICK, 64'h7777_7777_7777_7777, 1'b0);

    // triangles against a tight index budget: second triangle overflows
    settle();
    write_config(pvk_pkg::PRIM_TRI, 256, 4);
    add_kick(pvk_pkg::ACTION_KICK, 64'h0000_0000_ffff_ffff, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'hffff_ffff_0000_0000, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'h3c3c_3c3c_3c3c_3c3c, 1'b0);
    add_kick(pvk_pkg::ACTION_KICK, 64'hc3c3_c3c3_c3c3_c3c3, 1'b0);

    // random phases over every type and a spread of capacities
    run_random(pvk_pkg::PRIM_LINE,      256, 65535, 3, 10, 25, 1'b0);
    run_random(pvk_pkg::PRIM_LINESTRIP, 256, 65535, 3, 30, 25, 1'b0);
    run_random(pvk_pkg::PRIM_TRI,        16, 65535, 5, 10, 25, 1'b0);
    run_random(pvk_pkg::PRIM_TRISTRIP,   64, 65535, 3, 30, 25, 1'b0);
    run_random(pvk_pkg::PRIM_FAN,         8, 65535, 6, 20, 25, 1'b0);
    run_random(pvk_pkg::PRIM_SPRITE,    256,    40, 3, 10, 25, 1'b0);
    run_random(pvk_pkg::PRIM_INVALID,     3,     9, 10, 20, 15, 1'b0);
    run_random(pvk_pkg::PRIM_POINT,     256,     1, 20, 10, 20, 1'b0);

    // points with only a leading flush run the whole store into overflow; the long hold lands here
    run_random(pvk_pkg::PRIM_POINT,     256, 65535, 0, 2, 270, 1'b1);

    // closing stretch with both sides always ready
    settle();
    no_idle = 1'b1;
    run_random(pvk_pkg::PRIM_TRISTRIP,  256, 65535, 4, 20, 35, 1'b1);

    settle();
    repeat (20) @(posedge clk);
    if (emitted_q.size() != 0)
      report_mismatch("result words never arrived", WORD_W'(emitted_q.size()), '0);
    if (n_errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
